FILE: rtl/rfs_pkg.sv
// Shared types, register codes and helpers for the running field statistics block.
package rfs_pkg;

   localparam int unsigned MAX_COMPONENTS = 3;

   // Configuration register indexes
   localparam logic [2:0] CSR_MAGNITUDE_MODE   = 3'd0;
   localparam logic [2:0] CSR_COMPONENT_SELECT = 3'd1;
   localparam logic [2:0] CSR_COMPONENT_COUNT  = 3'd2;
   localparam logic [2:0] CSR_GHOST_MASK       = 3'd3;
   localparam logic [2:0] CSR_MOMENTS_ENABLE   = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECIDE, ST_MAG_MUL, ST_MAG_ACC, ST_MAG_WAIT, ST_MOM, ST_MEAN_WAIT,
      ST_DEV_MUL, ST_M2_ADD, ST_SQ_MUL, ST_MS_DIV, ST_MS_WAIT, ST_COMMIT, ST_LAST,
      ST_VAR_WAIT, ST_RMS, ST_RMS_WAIT, ST_STD, ST_STD_WAIT, ST_EMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_PICK_COMP, OP_MAG_MUL, OP_MAG_ACC, OP_MAG_ROOT, OP_PICK_MAG,
      OP_MEAN_DIV, OP_MEAN_SET, OP_DEV_MUL, OP_M2_ADD, OP_SQ_MUL, OP_MS_DIV, OP_MS_SET,
      OP_COMMIT, OP_VAR_DIV, OP_VAR_SET, OP_RMS_ROOT, OP_RMS_SET, OP_STD_ROOT,
      OP_STD_SET, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic last;
      logic mag_mode;
      logic mag_more;
      logic moments;
      logic seen;
      logic div_done;
      logic root_done;
      logic rsp_free;
   } status_type;

   // Magnitude of a signed 32-bit word as an unsigned 32-bit word
   function automatic logic [31:0] abs32(input logic [31:0] x);
      abs32 = x[31] ? (~x + 32'd1) : x;
   endfunction

   // Magnitude of a signed 33-bit difference, which always fits 32 bits here
   function automatic logic [31:0] abs33(input logic [32:0] x);
      logic [32:0] m;
      m = x[32] ? (~x + 33'd1) : x;
      abs33 = m[31:0];
   endfunction

endpackage

FILE: rtl/rfs_div.sv
// Iterative restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
module rfs_div import rfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        short_op,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;

   // One shift / compare / subtract step
   always_comb begin
      rem_sh  = {rem_ff, q_ff[63]};
      rem_sub = rem_sh - {1'b0, d_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // short form: the dividend arrives pre-shifted, only 32 steps needed
         q_in    = dividend;
         rem_in  = '0;
         d_in    = divisor;
         cnt_in  = short_op ? 7'd32 : 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, d_ff}) begin
            rem_in = rem_sub[31:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: rtl/rfs_sqrt.sv
// Iterative floor square root of a 64-bit word, one result bit per cycle.
module rfs_sqrt import rfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] v_ff, v_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic [35:0] rem_sub;

   // Bit-pair step: bring down two bits, try root*4+1
   always_comb begin
      rem_sh  = {rem_ff, v_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      rem_sub = rem_sh - trial;
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in = {v_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sub[33:0];
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: rtl/rfs_datapath.sv
// Datapath: configuration, statistics registers, multiplier, divider, root unit, result beat.
module rfs_datapath import rfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_write_data,
   input  logic signed [31:0] req_component_zero,
   input  logic signed [31:0] req_component_one,
   input  logic signed [31:0] req_component_two,
   input  logic [7:0]         req_ghost_bits,
   input  logic               req_not_finite,
   input  logic [31:0]        req_tuple_index,
   input  logic               req_last_tuple,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_any_valid,
   output logic [31:0]        rsp_counted_total,
   output logic signed [31:0] rsp_minimum_value,
   output logic signed [31:0] rsp_maximum_value,
   output logic [31:0]        rsp_minimum_index,
   output logic [31:0]        rsp_maximum_index,
   output logic signed [31:0] rsp_mean_value,
   output logic [62:0]        rsp_variance_value,
   output logic [31:0]        rsp_rms_value,
   output logic [31:0]        rsp_stddev_value
);

   // configuration
   logic       mag_mode_ff, moments_ff;
   logic [1:0] sel_ff, ccount_ff;
   logic [7:0] ghost_mask_ff;

   // captured tuple
   logic [31:0] comp0_ff, comp1_ff, comp2_ff, idx_ff;
   logic        skip_ff, last_ff;

   // working values
   logic [63:0] sum_ff, prod_ff;
   logic [1:0]  k_ff;
   logic [31:0] value_ff;
   logic        delta_neg_ff, diff_neg_ff;
   logic [31:0] delta_abs_ff;
   logic [62:0] var_ff;
   logic [31:0] rms_ff, std_ff;

   // statistics
   logic        seen_ff;
   logic [31:0] count_ff, min_ff, max_ff, min_pos_ff, max_pos_ff, mean_ff;
   logic [63:0] m2_ff, ms_ff;

   // result beat
   logic        rsp_valid_ff, rsp_any_ff;
   logic [31:0] rsp_count_ff, rsp_min_ff, rsp_max_ff, rsp_min_pos_ff, rsp_max_pos_ff;
   logic [31:0] rsp_mean_ff, rsp_rms_ff, rsp_std_ff;
   logic [62:0] rsp_var_ff;

   logic [1:0]  cnt_lim;
   logic [31:0] comp_k, comp_sel, n_value;
   logic [32:0] delta, dev, mean_new;
   logic [64:0] diff, m2_sum;
   logic [63:0] diff_abs;
   logic        div_start, div_short, div_done, root_start, root_done;
   logic [63:0] div_dividend, div_quot, root_radicand;
   logic [31:0] div_divisor, root_out;
   logic        is_lo, is_hi;

   // Component chosen for the multiplier and for component mode
   always_comb begin
      cnt_lim = (ccount_ff > 2'(MAX_COMPONENTS)) ? 2'(MAX_COMPONENTS) : ccount_ff;
      unique case (k_ff)
         2'd1:    comp_k = comp1_ff;
         2'd2:    comp_k = comp2_ff;
         default: comp_k = comp0_ff;
      endcase
      if (sel_ff == 2'd1 && MAX_COMPONENTS > 1) begin
         comp_sel = comp1_ff;
      end else if (sel_ff == 2'd2 && MAX_COMPONENTS > 2) begin
         comp_sel = comp2_ff;
      end else begin
         comp_sel = comp0_ff;
      end
   end

   // Arithmetic between the registers
   always_comb begin
      n_value  = (count_ff == '1) ? count_ff : count_ff + 32'd1;
      delta    = {value_ff[31], value_ff} - {mean_ff[31], mean_ff};
      dev      = {value_ff[31], value_ff} - {mean_ff[31], mean_ff};
      mean_new = delta_neg_ff ? ({mean_ff[31], mean_ff} - {1'b0, div_quot[31:0]})
                              : ({mean_ff[31], mean_ff} + {1'b0, div_quot[31:0]});
      diff     = {1'b0, prod_ff} - {1'b0, ms_ff};
      diff_abs = diff[64] ? (~diff[63:0] + 64'd1) : diff[63:0];
      m2_sum   = {1'b0, m2_ff} + {1'b0, prod_ff};
      is_lo    = $signed(value_ff) < $signed(min_ff);
      is_hi    = $signed(value_ff) > $signed(max_ff);
   end

   // Divider and root unit operand selection
   always_comb begin
      div_start     = 1'b0;
      div_short     = 1'b0;
      div_dividend  = {m2_ff};
      div_divisor   = count_ff;
      root_start    = 1'b0;
      root_radicand = sum_ff;
      unique case (cmd.op)
         OP_MEAN_DIV: begin
            div_start    = 1'b1;
            div_short    = 1'b1;
            div_dividend = {abs33(delta), 32'd0};
            div_divisor  = n_value;
         end
         OP_MS_DIV: begin
            div_start    = 1'b1;
            div_dividend = diff_abs;
            div_divisor  = n_value;
         end
         OP_VAR_DIV:  div_start = 1'b1;
         OP_MAG_ROOT: root_start = 1'b1;
         OP_RMS_ROOT: begin
            root_start    = 1'b1;
            root_radicand = ms_ff;
         end
         OP_STD_ROOT: begin
            root_start    = 1'b1;
            root_radicand = {1'b0, var_ff};
         end
         default: ;
      endcase
   end

   rfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .short_op (div_short),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   rfs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_radicand),
      .done     (root_done),
      .root     (root_out)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_mode_ff   <= 1'b0;
         sel_ff        <= 2'd0;
         ccount_ff     <= 2'd1;
         ghost_mask_ff <= 8'd3;
         moments_ff    <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAGNITUDE_MODE:   mag_mode_ff   <= csr_write_data[0];
            CSR_COMPONENT_SELECT: sel_ff        <= csr_write_data[1:0];
            CSR_COMPONENT_COUNT:  ccount_ff     <= csr_write_data[1:0];
            CSR_GHOST_MASK:       ghost_mask_ff <= csr_write_data;
            CSR_MOMENTS_ENABLE:   moments_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Working registers (payload, no reset)
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            comp0_ff <= req_component_zero;
            comp1_ff <= req_component_one;
            comp2_ff <= req_component_two;
            idx_ff   <= req_tuple_index;
            skip_ff  <= ((req_ghost_bits & ghost_mask_ff) != 8'd0) || req_not_finite;
            last_ff  <= req_last_tuple;
            sum_ff   <= '0;
            k_ff     <= 2'd0;
         end
         OP_PICK_COMP: value_ff <= comp_sel;
         OP_MAG_MUL:   prod_ff  <= abs32(comp_k) * abs32(comp_k);
         OP_MAG_ACC: begin
            sum_ff <= sum_ff + prod_ff;
            k_ff   <= k_ff + 2'd1;
         end
         OP_PICK_MAG:  value_ff <= root_out[31] ? 32'h7FFF_FFFF : root_out;
         OP_MEAN_DIV: begin
            delta_neg_ff <= delta[32];
            delta_abs_ff <= abs33(delta);
         end
         OP_DEV_MUL:   prod_ff  <= delta_abs_ff * abs33(dev);
         OP_SQ_MUL:    prod_ff  <= abs32(value_ff) * abs32(value_ff);
         OP_MS_DIV:    diff_neg_ff <= diff[64];
         OP_VAR_SET:   var_ff   <= div_quot[63] ? '1 : div_quot[62:0];
         OP_RMS_SET:   rms_ff   <= root_out;
         OP_STD_SET:   std_ff   <= root_out;
         default: ;
      endcase
   end

   // Statistics state
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= 1'b0;
         count_ff   <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         min_pos_ff <= '0;
         max_pos_ff <= '0;
         mean_ff    <= '0;
         m2_ff      <= '0;
         ms_ff      <= '0;
      end else begin
         unique case (cmd.op)
            OP_MEAN_SET: mean_ff <= mean_new[31:0];
            OP_M2_ADD:   m2_ff   <= m2_sum[64] ? '1 : m2_sum[63:0];
            OP_MS_SET:   ms_ff   <= diff_neg_ff ? ms_ff - div_quot : ms_ff + div_quot;
            OP_COMMIT: begin
               seen_ff <= 1'b1;
               if (count_ff != '1) begin
                  count_ff <= count_ff + 32'd1;
               end
               if (!seen_ff || is_lo) begin
                  min_ff     <= value_ff;
                  min_pos_ff <= idx_ff;
               end
               if (!seen_ff || is_hi) begin
                  max_ff     <= value_ff;
                  max_pos_ff <= idx_ff;
               end
            end
            OP_EMIT: begin
               seen_ff    <= 1'b0;
               count_ff   <= '0;
               min_ff     <= '0;
               max_ff     <= '0;
               min_pos_ff <= '0;
               max_pos_ff <= '0;
               mean_ff    <= '0;
               m2_ff      <= '0;
               ms_ff      <= '0;
            end
            default: ;
         endcase
      end
   end

   // Result register, held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_EMIT) begin
         rsp_any_ff     <= seen_ff;
         rsp_count_ff   <= count_ff;
         rsp_min_ff     <= min_ff;
         rsp_max_ff     <= max_ff;
         rsp_min_pos_ff <= min_pos_ff;
         rsp_max_pos_ff <= max_pos_ff;
         rsp_mean_ff    <= (seen_ff && moments_ff) ? mean_ff : '0;
         rsp_var_ff     <= (seen_ff && moments_ff) ? var_ff : '0;
         rsp_rms_ff     <= (seen_ff && moments_ff) ? rms_ff : '0;
         rsp_std_ff     <= (seen_ff && moments_ff) ? std_ff : '0;
      end
   end

   assign status.skip      = skip_ff;
   assign status.last      = last_ff;
   assign status.mag_mode  = mag_mode_ff;
   assign status.mag_more  = k_ff < cnt_lim;
   assign status.moments   = moments_ff;
   assign status.seen      = seen_ff;
   assign status.div_done  = div_done;
   assign status.root_done = root_done;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_any_valid      = rsp_any_ff;
   assign rsp_counted_total  = rsp_count_ff;
   assign rsp_minimum_value  = rsp_min_ff;
   assign rsp_maximum_value  = rsp_max_ff;
   assign rsp_minimum_index  = rsp_min_pos_ff;
   assign rsp_maximum_index  = rsp_max_pos_ff;
   assign rsp_mean_value     = rsp_mean_ff;
   assign rsp_variance_value = rsp_var_ff;
   assign rsp_rms_value      = rsp_rms_ff;
   assign rsp_stddev_value   = rsp_std_ff;

endmodule

FILE: rtl/rfs_ctrl.sv
// Controller: sequences the datapath through one tuple and the final result.
module rfs_ctrl import rfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // Next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:      if (req_valid) st_in = ST_DECIDE;
         ST_DECIDE: begin
            if (status.skip) begin
               st_in = ST_LAST;
            end else if (status.mag_mode) begin
               st_in = ST_MAG_MUL;
            end else begin
               st_in = ST_MOM;
            end
         end
         ST_MAG_MUL:   st_in = status.mag_more ? ST_MAG_ACC : ST_MAG_WAIT;
         ST_MAG_ACC:   st_in = ST_MAG_MUL;
         ST_MAG_WAIT:  if (status.root_done) st_in = ST_MOM;
         ST_MOM:       st_in = status.moments ? ST_MEAN_WAIT : ST_COMMIT;
         ST_MEAN_WAIT: if (status.div_done) st_in = ST_DEV_MUL;
         ST_DEV_MUL:   st_in = ST_M2_ADD;
         ST_M2_ADD:    st_in = ST_SQ_MUL;
         ST_SQ_MUL:    st_in = ST_MS_DIV;
         ST_MS_DIV:    st_in = ST_MS_WAIT;
         ST_MS_WAIT:   if (status.div_done) st_in = ST_COMMIT;
         ST_COMMIT:    st_in = ST_LAST;
         ST_LAST: begin
            if (!status.last) begin
               st_in = ST_IDLE;
            end else if (status.seen && status.moments) begin
               st_in = ST_VAR_WAIT;
            end else begin
               st_in = ST_EMIT;
            end
         end
         ST_VAR_WAIT:  if (status.div_done) st_in = ST_RMS;
         ST_RMS:       st_in = ST_RMS_WAIT;
         ST_RMS_WAIT:  if (status.root_done) st_in = ST_STD;
         ST_STD:       st_in = ST_STD_WAIT;
         ST_STD_WAIT:  if (status.root_done) st_in = ST_EMIT;
         ST_EMIT:      if (status.rsp_free) st_in = ST_IDLE;
         default:      st_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_DECIDE:    if (!status.skip && !status.mag_mode) cmd.op = OP_PICK_COMP;
         ST_MAG_MUL:   cmd.op = status.mag_more ? OP_MAG_MUL : OP_MAG_ROOT;
         ST_MAG_ACC:   cmd.op = OP_MAG_ACC;
         ST_MAG_WAIT:  if (status.root_done) cmd.op = OP_PICK_MAG;
         ST_MOM:       if (status.moments) cmd.op = OP_MEAN_DIV;
         ST_MEAN_WAIT: if (status.div_done) cmd.op = OP_MEAN_SET;
         ST_DEV_MUL:   cmd.op = OP_DEV_MUL;
         ST_M2_ADD:    cmd.op = OP_M2_ADD;
         ST_SQ_MUL:    cmd.op = OP_SQ_MUL;
         ST_MS_DIV:    cmd.op = OP_MS_DIV;
         ST_MS_WAIT:   if (status.div_done) cmd.op = OP_MS_SET;
         ST_COMMIT:    cmd.op = OP_COMMIT;
         ST_LAST:      if (status.last && status.seen && status.moments) cmd.op = OP_VAR_DIV;
         ST_VAR_WAIT:  if (status.div_done) cmd.op = OP_VAR_SET;
         ST_RMS:       cmd.op = OP_RMS_ROOT;
         ST_RMS_WAIT:  if (status.root_done) cmd.op = OP_RMS_SET;
         ST_STD:       cmd.op = OP_STD_ROOT;
         ST_STD_WAIT:  if (status.root_done) cmd.op = OP_STD_SET;
         ST_EMIT:      if (status.rsp_free) cmd.op = OP_EMIT;
         default:      cmd.op = OP_NONE;
      endcase
   end

endmodule

FILE: rtl/running_field_statistics.sv
// Top level: streaming minimum, maximum, mean, variance, RMS and stddev of a field.
//
//   channel  direction  ports     beat
//   req      in         req_*     one field tuple
//   rsp      out        rsp_*     one result, after a tuple marked last
//   csr      in         csr_*     register write, no wait
//
// A skipped tuple goes from idle through the decide and last states. With moments on a
// counted tuple is paced by the shared 1-bit-per-cycle divider (32 steps for the mean,
// 64 for the mean square), and in magnitude mode also by a multiply and add per component
// and the 32-step square root unit; with moments off the divider is not used.
// With moments on and data counted, the last tuple adds variance division and two roots.
// Reset is synchronous; a result waiting on rsp_ready stalls only the final step.
module running_field_statistics import rfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_component_zero,
   input  logic signed [31:0] req_component_one,
   input  logic signed [31:0] req_component_two,
   input  logic [7:0]         req_ghost_bits,
   input  logic               req_not_finite,
   input  logic [31:0]        req_tuple_index,
   input  logic               req_last_tuple,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_any_valid,
   output logic [31:0]        rsp_counted_total,
   output logic signed [31:0] rsp_minimum_value,
   output logic signed [31:0] rsp_maximum_value,
   output logic [31:0]        rsp_minimum_index,
   output logic [31:0]        rsp_maximum_index,
   output logic signed [31:0] rsp_mean_value,
   output logic [62:0]        rsp_variance_value,
   output logic [31:0]        rsp_rms_value,
   output logic [31:0]        rsp_stddev_value
);

   cmd_type    cmd;
   status_type status;

   rfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rfs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_component_zero (req_component_zero),
      .req_component_one  (req_component_one),
      .req_component_two  (req_component_two),
      .req_ghost_bits     (req_ghost_bits),
      .req_not_finite     (req_not_finite),
      .req_tuple_index    (req_tuple_index),
      .req_last_tuple     (req_last_tuple),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_any_valid      (rsp_any_valid),
      .rsp_counted_total  (rsp_counted_total),
      .rsp_minimum_value  (rsp_minimum_value),
      .rsp_maximum_value  (rsp_maximum_value),
      .rsp_minimum_index  (rsp_minimum_index),
      .rsp_maximum_index  (rsp_maximum_index),
      .rsp_mean_value     (rsp_mean_value),
      .rsp_variance_value (rsp_variance_value),
      .rsp_rms_value      (rsp_rms_value),
      .rsp_stddev_value   (rsp_stddev_value)
   );

endmodule
